@@ src/adsr_envelope_evaluator_defines.svh @@
// ---------------------------------------------------------------------------
// ADSR envelope evaluator assertion macros
// Shared property macros for the port checker.
// ---------------------------------------------------------------------------
`ifndef ADSR_ENVELOPE_EVALUATOR_DEFINES_SVH
`define ADSR_ENVELOPE_EVALUATOR_DEFINES_SVH

// same-cycle implication
`define ADSR_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("adsr check failed");

// next-cycle implication
`define ADSR_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("adsr check failed");

`endif

@@ src/adsr_pkg.sv @@
// ---------------------------------------------------------------------------
// ADSR envelope evaluator package
// Widths, register codes, phase codes and the divider cell record.
// ---------------------------------------------------------------------------
package adsr_pkg;

	localparam int TIME_WIDTH      = 24;
	localparam int LEVEL_FRAC_BITS = 15;

	localparam int LEN_W   = 23;
	localparam int SUS_W   = 16;
	localparam int LEVEL_W = 16;
	localparam int PHASE_W = 3;
	localparam int QW      = LEVEL_FRAC_BITS + 1;
	localparam int CMP_W   = ((TIME_WIDTH > LEN_W + 1) ? TIME_WIDTH : LEN_W + 1) + 1;
	localparam int EXT_W   = (QW > SUS_W) ? QW : SUS_W;
	localparam int NUM_W   = QW + LEN_W;
	localparam int IN_W    = ((TIME_WIDTH + 7) / 8) * 8;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [QW-1:0] ONE_LVL = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

	localparam logic [LEN_W-1:0] ATTACK_RST  = LEN_W'(2205);
	localparam logic [LEN_W-1:0] DECAY_RST   = LEN_W'(4410);
	localparam logic [SUS_W-1:0] SUSTAIN_RST = SUS_W'(22938);
	localparam logic [LEN_W-1:0] REL_RST     = LEN_W'(2205);
	localparam logic [LEN_W-1:0] NOTE_RST    = LEN_W'(22050);

	typedef enum logic [2:0] {
		REG_ATTACK  = 3'd0,
		REG_DECAY   = 3'd1,
		REG_SUSTAIN = 3'd2,
		REG_RELEASE = 3'd3,
		REG_NOTE    = 3'd4
	} reg_idx_t;

	typedef enum logic [PHASE_W-1:0] {
		PH_SILENT  = 3'd0,
		PH_ATTACK  = 3'd1,
		PH_DECAY   = 3'd2,
		PH_SUSTAIN = 3'd3,
		PH_RELEASE = 3'd4
	} phase_t;

	typedef struct packed {
		logic [LEN_W-1:0] attack_len;
		logic [LEN_W-1:0] decay_len;
		logic [SUS_W-1:0] sustain;
		logic [LEN_W-1:0] rel_len;
		logic [LEN_W-1:0] note_len;
	} cfg_t;

	typedef struct packed {
		phase_t           phase;
		logic [LEN_W-1:0] rem;
		logic [QW-1:0]    pend;
		logic [QW-1:0]    quo;
		logic [LEN_W-1:0] divisor;
		logic [QW-1:0]    direct;
	} div_cell_t;

endpackage

@@ src/adsr_envelope_evaluator.sv @@
// ---------------------------------------------------------------------------
// ADSR envelope evaluator
// Pipeline registers in order: decode, multiply, the divider cell row
// (each cell settles one quotient bit), output register.
// Throughput: one transfer per cycle; the whole pipeline holds on output stall.
// Reset: arst_n clears all valid bits and loads the register defaults.
// ---------------------------------------------------------------------------
module adsr_envelope_evaluator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [adsr_pkg::IN_W-1:0]     s_tdata,  // note_time
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [adsr_pkg::LEVEL_W-1:0]  m_tdata,  // level
	output logic [adsr_pkg::PHASE_W-1:0]  m_tuser,  // phase
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [adsr_pkg::ADDR_W-1:0]   paddr,
	input  logic [adsr_pkg::DATA_W-1:0]   pwdata,
	output logic [adsr_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	localparam int QW = adsr_pkg::QW;
	localparam int LW = adsr_pkg::LEN_W;

	adsr_pkg::cfg_t      cfg_q;
	adsr_pkg::reg_idx_t  reg_idx;
	logic                wr_en, en;

	logic                cell_valid [0:QW];
	adsr_pkg::div_cell_t chain     [0:QW];

	logic [QW-1:0]       level_c;
	logic                m_tvalid_q;
	logic [adsr_pkg::LEVEL_W-1:0] level_q;
	adsr_pkg::phase_t    phase_q;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = adsr_pkg::reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.attack_len <= adsr_pkg::ATTACK_RST;
			cfg_q.decay_len  <= adsr_pkg::DECAY_RST;
			cfg_q.sustain    <= adsr_pkg::SUSTAIN_RST;
			cfg_q.rel_len    <= adsr_pkg::REL_RST;
			cfg_q.note_len   <= adsr_pkg::NOTE_RST;
		end else if (wr_en) begin
			case (reg_idx)
				adsr_pkg::REG_ATTACK:  cfg_q.attack_len <= pwdata[LW-1:0];
				adsr_pkg::REG_DECAY:   cfg_q.decay_len  <= pwdata[LW-1:0];
				adsr_pkg::REG_SUSTAIN: cfg_q.sustain    <= pwdata[adsr_pkg::SUS_W-1:0];
				adsr_pkg::REG_RELEASE: cfg_q.rel_len    <= pwdata[LW-1:0];
				adsr_pkg::REG_NOTE:    cfg_q.note_len   <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::DATA_W'(cfg_q.attack_len);
			adsr_pkg::REG_DECAY:   prdata = adsr_pkg::DATA_W'(cfg_q.decay_len);
			adsr_pkg::REG_SUSTAIN: prdata = adsr_pkg::DATA_W'(cfg_q.sustain);
			adsr_pkg::REG_RELEASE: prdata = adsr_pkg::DATA_W'(cfg_q.rel_len);
			adsr_pkg::REG_NOTE:    prdata = adsr_pkg::DATA_W'(cfg_q.note_len);
			default:               prdata = '0;
		endcase
	end

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	adsr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.note_time (s_tdata[adsr_pkg::TIME_WIDTH-1:0]),
		.cfg       (cfg_q),
		.out_valid (cell_valid[0]),
		.out_cell  (chain[0])
	);

	for (genvar k = 0; k < QW; k++) begin : g_cell
		adsr_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (cell_valid[k]),
			.in_cell   (chain[k]),
			.out_valid (cell_valid[k+1]),
			.out_cell  (chain[k+1])
		);
	end

	always_comb begin
		case (chain[QW].phase)
			adsr_pkg::PH_ATTACK:  level_c = chain[QW].quo;
			adsr_pkg::PH_DECAY:   level_c = adsr_pkg::ONE_LVL - chain[QW].quo;
			adsr_pkg::PH_RELEASE: level_c = chain[QW].quo;
			default:              level_c = chain[QW].direct;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= cell_valid[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			level_q <= adsr_pkg::LEVEL_W'(level_c);
			phase_q <= chain[QW].phase;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = level_q;
	assign m_tuser  = phase_q;

endmodule

@@ src/adsr_front.sv @@
// ---------------------------------------------------------------------------
// ADSR front end
// Phase decode and numerator multiply ahead of the divider chain.
// ---------------------------------------------------------------------------
module adsr_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            in_valid,
	input  logic [adsr_pkg::TIME_WIDTH-1:0] note_time,
	input  adsr_pkg::cfg_t                  cfg,
	output logic                            out_valid,
	output adsr_pkg::div_cell_t             out_cell
);

	localparam int CW = adsr_pkg::CMP_W;
	localparam int LW = adsr_pkg::LEN_W;
	localparam int QW = adsr_pkg::QW;

	logic signed [CW-1:0] t_x, a_x, ad_x, nr_x, n_x;
	logic [CW-1:0]        into_x, left_x;
	logic [adsr_pkg::EXT_W-1:0] s_ext;
	logic [QW-1:0]        s_cl;

	adsr_pkg::phase_t     phase_c;
	logic [QW-1:0]        mul_a_c, direct_c;
	logic [LW-1:0]        mul_b_c, div_c;

	logic                 valid_s1;
	adsr_pkg::phase_t     phase_s1;
	logic [QW-1:0]        mul_a_s1, direct_s1;
	logic [LW-1:0]        mul_b_s1, div_s1;

	logic                 valid_s2;
	adsr_pkg::phase_t     phase_s2;
	logic [adsr_pkg::NUM_W-1:0] num_s2;
	logic [QW-1:0]        direct_s2;
	logic [LW-1:0]        div_s2;

	always_comb begin
		t_x    = {{(CW - adsr_pkg::TIME_WIDTH){note_time[adsr_pkg::TIME_WIDTH-1]}}, note_time};
		a_x    = CW'(cfg.attack_len);
		ad_x   = CW'(cfg.attack_len) + CW'(cfg.decay_len);
		nr_x   = CW'(cfg.note_len) - CW'(cfg.rel_len);
		n_x    = CW'(cfg.note_len);
		into_x = t_x - a_x;
		left_x = n_x - t_x;
		s_ext  = adsr_pkg::EXT_W'(cfg.sustain);
		s_cl   = (s_ext > adsr_pkg::EXT_W'(adsr_pkg::ONE_LVL)) ?
			adsr_pkg::ONE_LVL : QW'(s_ext);

		phase_c  = adsr_pkg::PH_SILENT;
		mul_a_c  = '0;
		mul_b_c  = '0;
		div_c    = cfg.attack_len;
		direct_c = '0;
		if (t_x < 0) begin
			phase_c = adsr_pkg::PH_SILENT;
		end else if (t_x < a_x) begin
			phase_c = adsr_pkg::PH_ATTACK;
			mul_a_c = adsr_pkg::ONE_LVL;
			mul_b_c = t_x[LW-1:0];
			div_c   = cfg.attack_len;
		end else if (t_x < ad_x) begin
			phase_c = adsr_pkg::PH_DECAY;
			mul_a_c = adsr_pkg::ONE_LVL - s_cl;
			mul_b_c = into_x[LW-1:0];
			div_c   = cfg.decay_len;
		end else if (t_x < nr_x) begin
			phase_c  = adsr_pkg::PH_SUSTAIN;
			direct_c = s_cl;
		end else if (t_x < n_x) begin
			phase_c = adsr_pkg::PH_RELEASE;
			mul_a_c = s_cl;
			mul_b_c = left_x[LW-1:0];
			div_c   = cfg.rel_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phase_s1  <= phase_c;
			mul_a_s1  <= mul_a_c;
			mul_b_s1  <= mul_b_c;
			div_s1    <= div_c;
			direct_s1 <= direct_c;
			phase_s2  <= phase_s1;
			num_s2    <= adsr_pkg::NUM_W'(mul_a_s1) * adsr_pkg::NUM_W'(mul_b_s1);
			div_s2    <= div_s1;
			direct_s2 <= direct_s1;
		end
	end

	always_comb begin
		out_valid        = valid_s2;
		out_cell.phase   = phase_s2;
		out_cell.rem     = num_s2[adsr_pkg::NUM_W-1:QW];
		out_cell.pend    = num_s2[QW-1:0];
		out_cell.quo     = '0;
		out_cell.divisor = div_s2;
		out_cell.direct  = direct_s2;
	end

endmodule

@@ src/adsr_div_cell.sv @@
// ---------------------------------------------------------------------------
// ADSR divider cell
// One restoring division step: settle one quotient bit and hand on.
// ---------------------------------------------------------------------------
module adsr_div_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  adsr_pkg::div_cell_t in_cell,
	output logic                out_valid,
	output adsr_pkg::div_cell_t out_cell
);

	localparam int LW = adsr_pkg::LEN_W;
	localparam int QW = adsr_pkg::QW;

	logic [LW:0]   rem2, diff;
	logic          ge;
	logic          valid_q;
	adsr_pkg::div_cell_t cell_q, cell_d;

	always_comb begin
		rem2           = {in_cell.rem, in_cell.pend[QW-1]};
		diff           = rem2 - {1'b0, in_cell.divisor};
		ge             = rem2 >= {1'b0, in_cell.divisor};
		cell_d         = in_cell;
		cell_d.rem     = ge ? diff[LW-1:0] : rem2[LW-1:0];
		cell_d.pend    = {in_cell.pend[QW-2:0], 1'b0};
		cell_d.quo     = {in_cell.quo[QW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cell_q <= cell_d;
		end
	end

	assign out_valid = valid_q;
	assign out_cell  = cell_q;

endmodule

@@ src/adsr_checker.sv @@
// ---------------------------------------------------------------------------
// ADSR port checker
// Stream-side checks on the top level ports, bound to the top level.
// ---------------------------------------------------------------------------
`include "adsr_envelope_evaluator_defines.svh"

module adsr_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [adsr_pkg::LEVEL_W-1:0]  m_tdata,
	input logic [adsr_pkg::PHASE_W-1:0]  m_tuser
);

	`ADSR_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`ADSR_ASSERT_IMP(a_silent_zero, m_tvalid && (m_tuser == adsr_pkg::PH_SILENT), m_tdata == '0)
	`ADSR_ASSERT_IMP(a_stall_in, m_tvalid && !m_tready, !s_tready)
	`ADSR_ASSERT_IMP(a_ready_cause, !s_tready, m_tvalid)

endmodule

bind adsr_envelope_evaluator adsr_checker u_adsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
